// File: design/csc_pkg.sv
package csc_pkg;

  localparam int unsigned FUNC_W     = 3;
  localparam int unsigned LEVEL_W    = 11;
  localparam int unsigned VALUE_W    = 8;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned SUM_W      = 16;
  localparam int unsigned INDEX_W    = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] RISE_RST    = LEVEL_W'(3);
  localparam logic [LEVEL_W-1:0] SETTLE_RST  = LEVEL_W'(2);
  localparam logic [LEVEL_W-1:0] MATCH_RST   = LEVEL_W'(9);
  localparam logic [SUM_W-1:0]   NOTIFY_RST  = SUM_W'(5);
  localparam logic [SUM_W-1:0]   COIN_ABSENT = 16'hffff;
  localparam logic [SUM_W-1:0]   QUIET_MAX   = 16'hffff;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE = 3'd0,
    FUNC_TICK   = 3'd1,
    FUNC_TAKE   = 3'd2,
    FUNC_LOAD   = 3'd3,
    FUNC_QUERY  = 3'd4
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EMPTY_LEVEL    = 3'd0,
    CFG_RISE_THRESHOLD = 3'd1,
    CFG_SETTLE_TOL     = 3'd2,
    CFG_MATCH_TOL      = 3'd3,
    CFG_NOTIFY_DELAY   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [VALUE_W-1:0] value;
    logic [LEVEL_W-1:0] level;
  } entry_t;

  function automatic logic [LEVEL_W-1:0] abs_diff(input logic [LEVEL_W-1:0] a,
                                                  input logic [LEVEL_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: design/csc_ifs.sv
interface csc_in_if;
  import csc_pkg::*;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [LEVEL_W-1:0] sample;
  logic [INDEX_W-1:0] entry_index;
  logic [VALUE_W-1:0] coin_value;
  logic [LEVEL_W-1:0] coin_level;

  modport source(output valid, func, sample, entry_index, coin_value, coin_level,
                 input ready);
  modport sink(input valid, func, sample, entry_index, coin_value, coin_level,
               output ready);
endinterface

interface csc_out_if;
  import csc_pkg::*;
  logic               valid;
  logic               ready;
  logic               coin_event;
  logic               matched;
  logic [INDEX_W-1:0] matched_index;
  logic [SUM_W-1:0]   total_sum;
  logic [SUM_W-1:0]   coin_sum;
  logic [SUM_W-1:0]   taken_sum;

  modport source(output valid, coin_event, matched, matched_index, total_sum,
                 coin_sum, taken_sum, input ready);
  modport sink(input valid, coin_event, matched, matched_index, total_sum,
               coin_sum, taken_sum, output ready);
endinterface

interface csc_cfg_if;
  import csc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: design/coin_signal_classifier_unit.sv
// Coin classifier: one result per input item, in order. The coin table (value,
// level, count per entry) sits in a single-port-read RAM with a registered read.
// A sample that does not complete a passage, a tick, a take and an unused
// function code go straight to the finish state; a load reads the old entry,
// then writes the new one back. A completing sample or a query walks the table
// one entry per cycle with compares pipelined behind reads, stopping at the
// first hit or after the last entry on a miss. The next item is
// taken while the previous result still waits at the output register. The
// table reads as all zero after reset through per-entry valid bits; no clearing
// pass is needed. Configuration writes are taken in any cycle.
module coin_signal_classifier_unit #(
  parameter int unsigned NUM_ENTRIES = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  csc_in_if.sink    in_i,
  csc_out_if.source out_o,
  csc_cfg_if.sink   cfg_i
);
  import csc_pkg::*;

  localparam int unsigned IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned EW = $bits(entry_t);

  state_e state_q, state_d;

  logic [LEVEL_W-1:0] empty_q, rise_q, settle_q, match_q;
  logic [SUM_W-1:0]   notify_q;

  logic [LEVEL_W-1:0] peak_q, peak_d;
  logic               armed_q, armed_d;
  logic [SUM_W-1:0]   active_q, active_d;
  logic [SUM_W-1:0]   quiet_q, quiet_d;
  logic [SUM_W-1:0]   total_q, total_d;
  logic [NUM_ENTRIES-1:0] valid_q, valid_d;

  logic               query_q, query_d;
  logic [LEVEL_W-1:0] key_level_q, key_level_d;
  logic [VALUE_W-1:0] key_value_q, key_value_d;
  logic [IW-1:0]      entry_idx_q, entry_idx_d;
  logic [CW-1:0]      iss_q, iss_d;
  logic               rvalid_q, rvalid_d;
  logic [IW-1:0]      cmp_idx_q, cmp_idx_d;

  logic               res_ev_q, res_ev_d;
  logic               res_mt_q, res_mt_d;
  logic [INDEX_W-1:0] res_mi_q, res_mi_d;
  logic [SUM_W-1:0]   res_csum_q, res_csum_d;
  logic [SUM_W-1:0]   res_taken_q, res_taken_d;

  logic               out_valid_q, out_valid_d;
  logic               out_ev_q, out_mt_q;
  logic [INDEX_W-1:0] out_mi_q;
  logic [SUM_W-1:0]   out_total_q, out_csum_q, out_taken_q;
  logic               out_load;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata, ent;

  logic               in_xfer, out_xfer;
  logic [LEVEL_W-1:0] peak_max;
  logic               arm, settle;
  logic               hit, last_cmp, scan_issue;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // Sample-side decisions, evaluated on the accepted item.
  assign peak_max = (in_i.sample > peak_q) ? in_i.sample : peak_q;
  assign arm      = armed_q || ((in_i.sample > empty_q) &&
                                ((in_i.sample - empty_q) > rise_q));
  assign settle   = arm && (abs_diff(in_i.sample, empty_q) < settle_q);

  // Entries never written read as zero.
  assign ent        = valid_q[cmp_idx_q] ? ram_rdata : entry_t'('0);
  assign hit        = rvalid_q && (query_q ? (ent.value == key_value_q)
                                           : (abs_diff(key_level_q, ent.level) < match_q));
  assign last_cmp   = (cmp_idx_q == IW'(NUM_ENTRIES - 1));
  assign scan_issue = (state_q == ST_SCAN) && (iss_q < CW'(NUM_ENTRIES));

  always_comb begin
    entry_t old_ent;
    old_ent     = valid_q[entry_idx_q] ? ram_rdata : entry_t'('0);
    state_d     = state_q;
    peak_d      = peak_q;
    armed_d     = armed_q;
    active_d    = active_q;
    quiet_d     = quiet_q;
    total_d     = total_q;
    valid_d     = valid_q;
    query_d     = query_q;
    key_level_d = key_level_q;
    key_value_d = key_value_q;
    entry_idx_d = entry_idx_q;
    iss_d       = iss_q;
    rvalid_d    = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    res_ev_d    = res_ev_q;
    res_mt_d    = res_mt_q;
    res_mi_d    = res_mi_q;
    res_csum_d  = res_csum_q;
    res_taken_d = res_taken_q;
    out_valid_d = out_valid_q && !out_xfer;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = entry_idx_q;
    ram_wdata   = entry_t'('0);
    ram_re      = 1'b0;
    ram_raddr   = entry_idx_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          res_ev_d    = 1'b0;
          res_mt_d    = 1'b0;
          res_mi_d    = '0;
          res_csum_d  = '0;
          res_taken_d = '0;
          iss_d       = '0;
          key_value_d = in_i.coin_value;
          state_d     = ST_FINISH;
          case (in_i.func)
            FUNC_SAMPLE: begin
              if (settle) begin
                peak_d      = in_i.sample;
                armed_d     = 1'b0;
                key_level_d = peak_max;
                query_d     = 1'b0;
                res_ev_d    = 1'b1;
                state_d     = ST_SCAN;
              end else begin
                peak_d  = peak_max;
                armed_d = arm;
              end
            end
            FUNC_TICK: begin
              if (quiet_q != QUIET_MAX) begin
                quiet_d = quiet_q + SUM_W'(1);
              end
            end
            FUNC_TAKE: begin
              if ((quiet_q > notify_q) && (active_q != '0)) begin
                res_taken_d = active_q;
                active_d    = '0;
              end
            end
            FUNC_LOAD: begin
              // Drop loads aimed past the table.
              if ({29'd0, in_i.entry_index} < 32'(NUM_ENTRIES)) begin
                entry_idx_d = IW'(in_i.entry_index);
                key_level_d = in_i.coin_level;
                state_d     = ST_LOAD_RD;
              end
            end
            FUNC_QUERY: begin
              query_d = 1'b1;
              state_d = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue entry iss_q while comparing the entry read last cycle.
        ram_re    = scan_issue;
        ram_raddr = iss_q[IW-1:0];
        if (scan_issue) begin
          iss_d     = iss_q + CW'(1);
          rvalid_d  = 1'b1;
          cmp_idx_d = iss_q[IW-1:0];
        end
        if (hit) begin
          rvalid_d = 1'b0;
          state_d  = ST_FINISH;
          if (query_q) begin
            res_csum_d = SUM_W'(ent.value * ent.count);
          end else begin
            ram_we              = 1'b1;
            ram_waddr           = cmp_idx_q;
            ram_wdata           = ent;
            ram_wdata.count     = ent.count + COUNT_W'(1);
            valid_d[cmp_idx_q]  = 1'b1;
            active_d            = active_q + SUM_W'(ent.value);
            total_d             = total_q + SUM_W'(ent.value);
            quiet_d             = '0;
            res_mt_d            = 1'b1;
            res_mi_d            = INDEX_W'(cmp_idx_q);
          end
        end else if (rvalid_q && last_cmp) begin
          rvalid_d = 1'b0;
          state_d  = ST_FINISH;
          if (query_q) begin
            res_csum_d = COIN_ABSENT;
          end
        end
      end

      ST_LOAD_RD: begin
        ram_re  = 1'b1;
        state_d = ST_LOAD_WR;
      end

      ST_LOAD_WR: begin
        // Retire the old entry's share of the total; the new count is zero.
        total_d                = total_q - SUM_W'(old_ent.value * old_ent.count);
        ram_we                 = 1'b1;
        ram_wdata.count        = '0;
        ram_wdata.value        = key_value_q;
        ram_wdata.level        = key_level_q;
        valid_d[entry_idx_q]   = 1'b1;
        state_d                = ST_FINISH;
      end

      ST_FINISH: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      peak_q      <= '0;
      armed_q     <= 1'b0;
      active_q    <= '0;
      quiet_q     <= '0;
      total_q     <= '0;
      valid_q     <= '0;
      rvalid_q    <= 1'b0;
      iss_q       <= '0;
      out_valid_q <= 1'b0;
      empty_q     <= '0;
      rise_q      <= RISE_RST;
      settle_q    <= SETTLE_RST;
      match_q     <= MATCH_RST;
      notify_q    <= NOTIFY_RST;
    end else begin
      state_q     <= state_d;
      peak_q      <= peak_d;
      armed_q     <= armed_d;
      active_q    <= active_d;
      quiet_q     <= quiet_d;
      total_q     <= total_d;
      valid_q     <= valid_d;
      rvalid_q    <= rvalid_d;
      iss_q       <= iss_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_EMPTY_LEVEL:    empty_q  <= cfg_i.data[LEVEL_W-1:0];
          CFG_RISE_THRESHOLD: rise_q   <= cfg_i.data[LEVEL_W-1:0];
          CFG_SETTLE_TOL:     settle_q <= cfg_i.data[LEVEL_W-1:0];
          CFG_MATCH_TOL:      match_q  <= cfg_i.data[LEVEL_W-1:0];
          CFG_NOTIFY_DELAY:   notify_q <= cfg_i.data[SUM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    query_q     <= query_d;
    key_level_q <= key_level_d;
    key_value_q <= key_value_d;
    entry_idx_q <= entry_idx_d;
    cmp_idx_q   <= cmp_idx_d;
    res_ev_q    <= res_ev_d;
    res_mt_q    <= res_mt_d;
    res_mi_q    <= res_mi_d;
    res_csum_q  <= res_csum_d;
    res_taken_q <= res_taken_d;
    if (out_load) begin
      out_ev_q    <= res_ev_q;
      out_mt_q    <= res_mt_q;
      out_mi_q    <= res_mi_q;
      out_total_q <= total_q;
      out_csum_q  <= res_csum_q;
      out_taken_q <= res_taken_q;
    end
  end

  csc_ram #(
    .WIDTH(EW),
    .DEPTH(NUM_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.coin_event    = out_ev_q;
  assign out_o.matched       = out_mt_q;
  assign out_o.matched_index = out_mi_q;
  assign out_o.total_sum     = out_total_q;
  assign out_o.coin_sum      = out_csum_q;
  assign out_o.taken_sum     = out_taken_q;

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_valid_q && !out_o.ready) |=> (state_q == ST_FINISH))
    else $error("result dropped while output register busy");

  a_hit_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && hit) |=> (state_q == ST_FINISH))
    else $error("scan continued past first hit");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_SCAN || state_q == ST_LOAD_WR))
    else $error("table written outside update states");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_i.ready)
    else $error("second item taken while one is in flight");

  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && ram_re) |-> (iss_q < CW'(NUM_ENTRIES)))
    else $error("scan read beyond table");

endmodule

// File: design/csc_ram.sv
module csc_ram #(
  parameter int unsigned WIDTH = 35,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
